// File: rtl/core/weighted_rcp_rate_update_macros.svh
// Assertion macros for the weighted RCP rate update block.
// Used by the top level; no other dependencies.
`ifndef WEIGHTED_RCP_RATE_UPDATE_MACROS_SVH
`define WEIGHTED_RCP_RATE_UPDATE_MACROS_SVH
`define WRU_ASSERT_IMP(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
	else $error("wru check failed");
`define WRU_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
	else $error("wru check failed");
`endif

// File: rtl/core/wru_pkg.sv
// Package for the weighted RCP rate update block: payload types and constants.
// No dependencies.
`default_nettype none
package wru_pkg;
	localparam int unsigned NUM_CLASSES_DEF = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_TX = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_FAIR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;
	localparam logic [1:0] ST_SKIP = 2'd0;
	localparam logic [1:0] ST_INTERVAL = 2'd1;
	localparam logic [1:0] ST_CLASS = 2'd2;
	localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

	typedef struct packed {
		logic        kind;
		logic [63:0] now_us;
		logic [63:0] total_bytes;
		logic [3:0]  class_index;
		logic [63:0] class_bytes;
		logic [15:0] class_weight;
		logic [31:0] class_min_rate;
		logic [31:0] class_max_rate;
		logic        class_is_static;
	} in_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [19:0] fair_rate;
		logic [31:0] aggregate_rate;
		logic [31:0] class_rate;
		logic [31:0] class_smooth;
		logic [31:0] class_limit;
	} out_word_t;

	typedef struct packed {
		logic        start;
		logic [66:0] num;
		logic [63:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [66:0] quo;
	} div_rsp_t;
endpackage
`default_nettype wire

// File: rtl/core/wru_div.sv
// Radix-2 restoring divider, one quotient bit per cycle, 67 by 64 bits.
// Depends on wru_pkg.
`default_nettype none
module wru_div (
	input  wire                clk,
	input  wire                arst_n,
	input  wru_pkg::div_req_t  req,
	output wru_pkg::div_rsp_t  rsp
);
	import wru_pkg::*;
	logic [66:0] q_q;
	logic [63:0] d_q;
	logic [64:0] r_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] sh;
	always_comb sh = {r_q[63:0], q_q[66]};
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done_q <= 1'b0;
			q_q <= '0;
			d_q <= '0;
			r_q <= '0;
		end else begin
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd67;
				q_q <= req.num;
				d_q <= req.den;
				r_q <= '0;
				done_q <= 1'b0;
			end else if (busy_q) begin
				if (sh >= {1'b0, d_q}) begin
					r_q <= sh - {1'b0, d_q};
					q_q <= {q_q[65:0], 1'b1};
				end else begin
					r_q <= sh;
					q_q <= {q_q[65:0], 1'b0};
				end
				cnt_q <= cnt_q - 7'd1;
				busy_q <= (cnt_q != 7'd1);
				done_q <= (cnt_q == 7'd1);
			end else begin
				done_q <= 1'b0;
			end
		end
	end
	assign rsp.done = done_q;
	assign rsp.quo = q_q;
endmodule
`default_nettype wire

// File: rtl/core/wru_class_mem.sv
// Per-class state memory: last byte counter and smoothed rate, registered read.
// No dependencies.
`default_nettype none
module wru_class_mem (
	input  wire         clk,
	input  wire [3:0]   rd_idx,
	output logic [95:0] rd_data,
	input  wire         wr_en,
	input  wire [3:0]   wr_idx,
	input  wire [95:0]  wr_data
);
	logic [95:0] mem [16];
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_idx] <= wr_data;
		rd_data <= mem[rd_idx];
	end
endmodule
`default_nettype wire

// File: rtl/core/weighted_rcp_rate_update.sv
// Weighted RCP rate update: one word at a time; a new word is taken only once the last
// result has been accepted. Class samples use one division on the 67-step bit-serial
// divider, interval updates two (one at zero capacity); skipped words use none. Reset
// restores the register defaults and clears the stamps, aggregate rate, open flag, class
// valid bits and out_valid; class entries count as zero until an entry is written.
// Depends on wru_pkg, wru_div, wru_class_mem and the macros header.
`default_nettype none
module weighted_rcp_rate_update #(
	parameter int unsigned NUM_CLASSES = wru_pkg::NUM_CLASSES_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  wru_pkg::in_word_t  in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output wru_pkg::out_word_t out_data,
	input  wire                cfg_we,
	input  wire [1:0]          cfg_index,
	input  wire [19:0]         cfg_data
);
	import wru_pkg::*;
	`include "weighted_rcp_rate_update_macros.svh"

	typedef enum logic [2:0] {S_IDLE, S_READ, S_DIV1, S_RCP, S_DIV2, S_CALC, S_OUT} state_t;
	state_t state_q;
	in_word_t item_q;
	logic [19:0] max_tx_q, min_fair_q, intv_q, fair_q;
	logic [63:0] last_us_q, last_tot_q, dt_q;
	logic [31:0] agg_q, crate_q;
	logic open_q;
	logic [15:0] valid_q;
	div_req_t dreq;
	div_rsp_t drsp;
	logic [3:0] rd_idx;
	logic [95:0] rd_data, wr_data;
	logic wr_en;
	logic [63:0] dt_c, old_bytes;
	logic [31:0] old_smooth;
	logic [31:0] rate_sat;
	logic [21:0] target, diff;
	logic [41:0] rcp_num;
	logic [66:0] fair_c;
	logic [35:0] csm;
	logic [35:0] lim;
	logic [31:0] lim2;
	logic due_c, cls_ok_c, div_go;

	wru_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));
	wru_class_mem u_mem (
		.clk(clk), .rd_idx(rd_idx), .rd_data(rd_data),
		.wr_en(wr_en), .wr_idx(item_q.class_index), .wr_data(wr_data));

	assign in_ready = (state_q == S_IDLE);
	assign rd_idx = in_ready ? in_data.class_index : item_q.class_index;
	assign dt_c = item_q.now_us - last_us_q;
	assign due_c = (dt_c != 64'd0) && (dt_c >= {44'd0, intv_q});
	assign cls_ok_c = open_q && (dt_q != 64'd0) && ({28'd0, item_q.class_index} < NUM_CLASSES);
	assign div_go = ((state_q == S_READ) && (item_q.kind ? cls_ok_c : due_c))
		|| ((state_q == S_RCP) && (max_tx_q != 20'd0));
	assign old_bytes = valid_q[item_q.class_index] ? rd_data[95:32] : 64'd0;
	assign old_smooth = valid_q[item_q.class_index] ? rd_data[31:0] : 32'd0;
	assign rate_sat = (drsp.quo > {35'd0, SAT32}) ? SAT32 : drsp.quo[31:0];
	assign target = 22'(3 * {2'd0, max_tx_q});
	assign diff = (target > {10'd0, crate_q}) ? target - crate_q[21:0] : 22'd0;
	assign rcp_num = {22'd0, fair_q} * {20'd0, diff};
	assign csm = ({4'd0, crate_q} + {old_smooth, 4'd0} - {4'd0, old_smooth});
	assign lim = {20'd0, item_q.class_weight} * {16'd0, fair_q};
	always_comb begin
		lim2 = (lim > {16'd0, max_tx_q}) ? {12'd0, max_tx_q} : lim[31:0];
		if (lim2 < item_q.class_min_rate) lim2 = item_q.class_min_rate;
		if (item_q.class_is_static && lim2 > item_q.class_max_rate)
			lim2 = item_q.class_max_rate;
	end
	always_comb begin
		fair_c = (max_tx_q == 20'd0) ? 67'd0 : drsp.quo;
		if (fair_c > {47'd0, max_tx_q}) fair_c = {47'd0, max_tx_q};
		if (fair_c < {47'd0, min_fair_q}) fair_c = {47'd0, min_fair_q};
	end
	assign wr_data = {item_q.class_bytes, csm[35:4]};
	assign wr_en = (state_q == S_CALC) && item_q.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			max_tx_q <= 20'd10000; min_fair_q <= 20'd10; intv_q <= 20'd1000;
			fair_q <= 20'd2; last_us_q <= '0; last_tot_q <= '0; agg_q <= '0;
			dt_q <= '0; open_q <= 1'b0; valid_q <= '0; out_valid <= 1'b0;
			dreq <= '0;
		end else begin
			dreq.start <= div_go;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAX_TX: max_tx_q <= cfg_data;
					REG_MIN_FAIR: min_fair_q <= cfg_data;
					REG_INTERVAL: intv_q <= cfg_data;
					default: ;
				endcase
			end
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					item_q <= in_data;
					state_q <= S_READ;
				end
				S_READ: begin
					out_data.fair_rate <= fair_q;
					out_data.aggregate_rate <= agg_q;
					out_data.class_rate <= '0;
					out_data.class_smooth <= '0;
					out_data.class_limit <= '0;
					out_data.status <= ST_SKIP;
					if (!item_q.kind) begin
						if (!due_c) begin
							open_q <= 1'b0;
							out_valid <= 1'b1;
							state_q <= S_OUT;
						end else begin
							dreq.num <= {item_q.total_bytes - last_tot_q, 3'b000};
							dreq.den <= dt_c;
							dt_q <= dt_c;
							state_q <= S_DIV1;
						end
					end else if (!cls_ok_c) begin
						out_valid <= 1'b1;
						state_q <= S_OUT;
					end else begin
						dreq.num <= {item_q.class_bytes - old_bytes, 3'b000};
						dreq.den <= dt_q;
						state_q <= S_DIV1;
					end
				end
				S_DIV1: if (drsp.done) begin
					crate_q <= rate_sat;
					state_q <= item_q.kind ? S_CALC : S_RCP;
				end
				S_RCP: begin
					dreq.num <= {25'd0, rcp_num};
					dreq.den <= {43'd0, max_tx_q, 1'b0};
					state_q <= (max_tx_q == 20'd0) ? S_CALC : S_DIV2;
				end
				S_DIV2: if (drsp.done) state_q <= S_CALC;
				S_CALC: begin
					if (!item_q.kind) begin
						fair_q <= fair_c[19:0];
						last_us_q <= item_q.now_us;
						last_tot_q <= item_q.total_bytes;
						agg_q <= crate_q;
						open_q <= 1'b1;
						out_data.status <= ST_INTERVAL;
						out_data.fair_rate <= fair_c[19:0];
						out_data.aggregate_rate <= crate_q;
					end else begin
						valid_q[item_q.class_index] <= 1'b1;
						out_data.status <= ST_CLASS;
						out_data.class_rate <= crate_q;
						out_data.class_smooth <= csm[35:4];
						out_data.class_limit <= lim2;
					end
					out_valid <= 1'b1;
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`WRU_ASSERT_IMP(a_ready_idle, clk, arst_n, in_ready, !out_valid)
	`WRU_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`WRU_ASSERT_IMP(a_fair_floor, clk, arst_n, out_valid && out_data.status == ST_INTERVAL,
		out_data.fair_rate >= min_fair_q || max_tx_q < min_fair_q)
endmodule
`default_nettype wire

// File: tb/weighted_rcp_rate_update_tb.sv
// Self-checking testbench for weighted_rcp_rate_update: directed table, register extremes,
// then random words, each result checked against an in-bench predictor. Depends on wru_pkg and the RTL.
`default_nettype none
module weighted_rcp_rate_update_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wru_pkg::*;

	localparam int NCLS = 16;
	localparam longint LIMIT = 2_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_ready = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [19:0] cfg_data = '0;
	in_word_t in_data = '0;
	logic in_ready, out_valid;
	out_word_t out_data;

	always #1 clk = ~clk;

	weighted_rcp_rate_update DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state
	logic [19:0] cap_rate, floor_rate, interval_us;
	logic [63:0] stamp_us, stamp_bytes, open_dt;
	logic [19:0] fair_now;
	logic [31:0] agg_now;
	logic window_open;
	logic [63:0] cls_bytes [NCLS];
	logic [31:0] cls_smooth [NCLS];

	out_word_t expected_words [$];
	int errors = 0;
	int checked = 0;
	int n_status [3] = '{0, 0, 0};
	longint cycles = 0;
	int send_idle = 0, recv_idle = 0;

	function automatic logic [31:0] measure_rate(logic [63:0] delta, logic [63:0] dt);
		logic [127:0] q;
		q = ({64'd0, delta} << 3) / {64'd0, dt};
		return (q > 128'hFFFF_FFFF) ? SAT32 : q[31:0];
	endfunction

	task automatic predict_reset();
		cap_rate = 20'd10000; floor_rate = 20'd10; interval_us = 20'd1000;
		stamp_us = '0; stamp_bytes = '0; open_dt = '0; fair_now = 20'd2;
		agg_now = '0; window_open = 1'b0;
		for (int i = 0; i < NCLS; i++) begin
			cls_bytes[i] = '0; cls_smooth[i] = '0;
		end
	endtask

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t r;
		logic [63:0] dt, diff, f, lim;
		logic [127:0] prod;
		r = '0;
		if (!w.kind) begin
			dt = w.now_us - stamp_us;
			if (dt == 0 || dt < {44'd0, interval_us}) begin
				window_open = 1'b0;
			end else begin
				agg_now = measure_rate(w.total_bytes - stamp_bytes, dt);
				diff = (3 * {44'd0, cap_rate} > {32'd0, agg_now}) ?
					3 * {44'd0, cap_rate} - {32'd0, agg_now} : 64'd0;
				if (cap_rate == 0) f = '0;
				else begin
					prod = {108'd0, fair_now} * {64'd0, diff};
					prod = prod / ({108'd0, cap_rate} << 1);
					f = prod[63:0];
				end
				if (f > {44'd0, cap_rate}) f = {44'd0, cap_rate};
				if (f < {44'd0, floor_rate}) f = {44'd0, floor_rate};
				fair_now = f[19:0];
				stamp_us = w.now_us; stamp_bytes = w.total_bytes;
				open_dt = dt; window_open = 1'b1;
				r.status = ST_INTERVAL;
			end
		end else if (window_open && open_dt != 0) begin
			r.class_rate = measure_rate(w.class_bytes - cls_bytes[w.class_index], open_dt);
			r.class_smooth = 32'(({32'd0, cls_smooth[w.class_index]} * 15 + r.class_rate) / 16);
			lim = {44'd0, fair_now} * {48'd0, w.class_weight};
			if (lim > {44'd0, cap_rate}) lim = {44'd0, cap_rate};
			if (lim < {32'd0, w.class_min_rate}) lim = {32'd0, w.class_min_rate};
			if (w.class_is_static && lim > {32'd0, w.class_max_rate})
				lim = {32'd0, w.class_max_rate};
			r.class_limit = lim[31:0];
			cls_bytes[w.class_index] = w.class_bytes;
			cls_smooth[w.class_index] = r.class_smooth;
			r.status = ST_CLASS;
		end
		r.fair_rate = fair_now;
		r.aggregate_rate = agg_now;
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0d want %0d (word %0d)", what, got, want, checked);
		errors++;
	endtask

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("[weighted_rcp_rate_update] ERROR");
			$finish;
		end
		if (out_valid && out_ready) begin
			if (expected_words.size() == 0) begin
				report_mismatch("unexpected word", 64'(out_data.status), 64'd0);
			end else begin
				out_word_t e;
				e = expected_words.pop_front();
				if (out_data.status !== e.status)
					report_mismatch("status", 64'(out_data.status), 64'(e.status));
				if (out_data.fair_rate !== e.fair_rate)
					report_mismatch("fair_rate", 64'(out_data.fair_rate), 64'(e.fair_rate));
				if (out_data.aggregate_rate !== e.aggregate_rate)
					report_mismatch("aggregate_rate", 64'(out_data.aggregate_rate),
						64'(e.aggregate_rate));
				if (out_data.class_rate !== e.class_rate)
					report_mismatch("class_rate", 64'(out_data.class_rate), 64'(e.class_rate));
				if (out_data.class_smooth !== e.class_smooth)
					report_mismatch("class_smooth", 64'(out_data.class_smooth),
						64'(e.class_smooth));
				if (out_data.class_limit !== e.class_limit)
					report_mismatch("class_limit", 64'(out_data.class_limit), 64'(e.class_limit));
				if (e.status <= ST_CLASS) n_status[e.status]++;
			end
			checked++;
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic write_reg(logic [1:0] idx, logic [19:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_MAX_TX) cap_rate = val;
		else if (idx == REG_MIN_FAIR) floor_rate = val;
		else if (idx == REG_INTERVAL) interval_us = val;
	endtask

	task automatic drain();
		while (expected_words.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
	endtask

	// one word, check-against-table when has_want is set
	task automatic send_word(in_word_t w, bit has_want = 1'b0, out_word_t want = '0);
		out_word_t p;
		@(negedge clk);
		while ($urandom_range(99) < send_idle) @(negedge clk);
		in_data <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		p = predict_word(w);
		if (has_want && p !== want)
			report_mismatch("table row", 64'(p.status), 64'(want.status));
		expected_words.push_back(p);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	function automatic in_word_t tick(logic [63:0] t, logic [63:0] b);
		in_word_t w;
		w = '0; w.kind = 1'b0; w.now_us = t; w.total_bytes = b;
		return w;
	endfunction

	function automatic in_word_t sample(logic [3:0] idx, logic [63:0] b, logic [15:0] wt,
			logic [31:0] mn, logic [31:0] mx, logic st);
		in_word_t w;
		w = '0; w.kind = 1'b1; w.class_index = idx; w.class_bytes = b; w.class_weight = wt;
		w.class_min_rate = mn; w.class_max_rate = mx; w.class_is_static = st;
		return w;
	endfunction

	function automatic logic [63:0] rnd64();
		case ($urandom_range(3))
			0: return {$urandom, $urandom};
			1: return 64'($urandom_range(5000));
			2: return 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(100);
			default: return {32'd0, $urandom};
		endcase
	endfunction

	logic [63:0] clock_us, byte_ctr;

	task automatic random_phase(int n);
		in_word_t w;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 8) begin
				clock_us += (($urandom_range(9) == 0) ? 64'($urandom_range(2000)) :
					{44'd0, interval_us} + $urandom_range(3000));
				byte_ctr += 64'($urandom) * $urandom_range(4);
				send_word(tick(clock_us, byte_ctr));
				repeat ($urandom_range(6)) begin
					logic [3:0] c;
					c = 4'($urandom_range(15));
					w = sample(c, cls_bytes[c] + $urandom_range(1 << 24), 16'($urandom),
						($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20000)),
						($urandom_range(3) == 0) ? $urandom : 32'($urandom_range(20000)),
						1'($urandom));
					if ($urandom_range(7) == 0) w.class_bytes = rnd64();
					send_word(w);
					i++;
				end
			end else begin
				w.kind = 1'($urandom);
				w.now_us = {$urandom, $urandom};
				w.total_bytes = {$urandom, $urandom};
				w.class_index = 4'($urandom);
				w.class_bytes = {$urandom, $urandom};
				w.class_weight = 16'($urandom);
				w.class_min_rate = $urandom;
				w.class_max_rate = $urandom;
				w.class_is_static = 1'($urandom);
				if (!w.kind && $urandom_range(1)) clock_us = w.now_us;
				send_word(w);
			end
		end
	endtask

	typedef struct {
		in_word_t w;
		bit has_want;
		out_word_t want;
	} row_t;

	row_t rows [$];

	initial begin
		out_word_t z;
		predict_reset();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (3) @(negedge clk);

		// after reset: a sample with no open interval, ticks not yet due, a first interval update; then unchecked rows
		z = '0; z.status = ST_SKIP; z.fair_rate = 20'd2;
		rows.push_back('{sample(4'd3, 64'd100, 16'd1, 32'd0, 32'd0, 1'b0), 1'b1, z});
		rows.push_back('{tick(64'd0, 64'd0), 1'b1, z});
		rows.push_back('{tick(64'd999, 64'd5), 1'b1, z});
		z.status = ST_INTERVAL; z.fair_rate = 20'd10;
		rows.push_back('{tick(64'd1000, 64'd0), 1'b1, z});
		rows.push_back('{sample(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 32'd0, 32'd0, 1'b0),
			1'b0, z});
		rows.push_back('{sample(4'd15, 64'd0, 16'd0, 32'hFFFF_FFFF, 32'd0, 1'b1), 1'b0, z});
		rows.push_back('{sample(4'd15, 64'd12345, 16'd7, 32'd0, 32'hFFFF_FFFF, 1'b1), 1'b0, z});
		rows.push_back('{sample(4'd15, 64'd99999, 16'd7, 32'd0, 32'd3, 1'b1), 1'b0, z});
		rows.push_back('{tick(64'd1500, 64'd9), 1'b0, z});
		rows.push_back('{sample(4'd1, 64'd50, 16'd2, 32'd0, 32'd0, 1'b0), 1'b0, z});
		rows.push_back('{tick(64'd100000, 64'hFFFF_FFFF_FFFF_FFFF), 1'b0, z});
		rows.push_back('{tick(64'd50, 64'd0), 1'b0, z});
		rows.push_back('{sample(4'd2, 64'd1, 16'd3, 32'd5, 32'd1, 1'b0), 1'b0, z});
		rows.push_back('{tick(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF), 1'b0, z});
		rows.push_back('{tick(64'hFFFF_FFFF_FFFF_FFFF, 64'd0), 1'b0, z});
		send_idle = 23; recv_idle = 46;
		foreach (rows[i]) send_word(rows[i].w, rows[i].has_want, rows[i].want);
		drain();

		// extremes of the registers, including zero capacity
		write_reg(REG_MAX_TX, 20'd0);
		write_reg(REG_MIN_FAIR, 20'hFFFFF);
		write_reg(REG_INTERVAL, 20'd0);
		clock_us = 64'd10; byte_ctr = 64'd0;
		send_word(tick(clock_us, 64'd5));
		send_word(sample(4'd9, 64'd77, 16'hFFFF, 32'd0, 32'd0, 1'b0));
		send_word(tick(clock_us, 64'd5));
		drain();

		write_reg(REG_MAX_TX, 20'd10000);
		write_reg(REG_MIN_FAIR, 20'd1);
		write_reg(REG_INTERVAL, 20'd1);
		clock_us = stamp_us; byte_ctr = stamp_bytes;
		random_phase(420);
		drain();

		send_idle = 46; recv_idle = 23;
		write_reg(REG_MAX_TX, 20'hFFFFF);
		write_reg(REG_MIN_FAIR, 20'd1000);
		write_reg(REG_INTERVAL, 20'hFFFFF);
		clock_us = stamp_us; byte_ctr = stamp_bytes;
		random_phase(420);
		drain();

		send_idle = 0; recv_idle = 0;
		write_reg(REG_MAX_TX, 20'd1);
		write_reg(REG_MIN_FAIR, 20'd1);
		write_reg(REG_INTERVAL, 20'd1000);
		write_reg(2'd3, 20'd5);
		clock_us = stamp_us; byte_ctr = stamp_bytes;
		random_phase(400);
		drain();

		$display("covered %0d words: %0d skipped, %0d interval updates, %0d class updates",
			checked, n_status[0], n_status[1], n_status[2]);
		$display("register settings from zero capacity to full scale, three idling patterns");
		if (errors == 0 && expected_words.size() == 0) begin
			$display("[weighted_rcp_rate_update] OK");
		end else begin
			$display("[weighted_rcp_rate_update] ERROR");
		end
		$finish;
	end
endmodule
`default_nettype wire
